### hdl/trajectory_line_fit_with_confidence_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef TRAJECTORY_LINE_FIT_WITH_CONFIDENCE_MACROS_SVH
`define TRAJECTORY_LINE_FIT_WITH_CONFIDENCE_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define TLF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");
// Condition must never be true out of reset.
`define TLF_NEVER(label, clk, rst_n, cond) \
    `TLF_ASSERT(label, clk, rst_n, !(cond))
`else
`define TLF_ASSERT(label, clk, rst_n, prop)
`define TLF_NEVER(label, clk, rst_n, cond)
`endif
`endif

### hdl/tlf_pkg.sv
package tlf_pkg;

    // Field widths
    localparam int TIME_W         = 20;
    localparam int SPEED_W        = 21;
    localparam int MINP_W         = 9;
    localparam int FIT_W          = 32;
    localparam int R2_W           = 17;
    localparam int RMS_W          = 22;
    localparam int SPAN_W         = 20;
    localparam int IN_TDATA_W     = 48;
    localparam int OUT_TDATA_W    = 192;

    // Defaults and limits
    localparam int MAX_POINTS_DEF = 256;
    localparam logic [MINP_W-1:0] MINP_RESET = 9'd5;
    localparam logic [R2_W-1:0]   R2_ONE     = 17'd65536;

    // One fit result
    typedef struct packed {
        logic                     ok;
        logic signed [FIT_W-1:0]  slope;
        logic signed [FIT_W-1:0]  icpt;
        logic [R2_W-1:0]          r2;
        logic [RMS_W-1:0]         rms;
        logic signed [FIT_W-1:0]  lo;
        logic signed [FIT_W-1:0]  hi;
        logic [SPAN_W-1:0]        span;
    } fit_result_t;

    // Fit engine status toward the output stage
    typedef struct packed {
        logic busy;
        logic done;
    } fit_stat_t;

endpackage

### hdl/tlf_acc.sv
module tlf_acc #(
    parameter int MAX_POINTS = tlf_pkg::MAX_POINTS_DEF,
    localparam int LOG_N = $clog2(MAX_POINTS),
    localparam int CNT_W = $clog2(MAX_POINTS + 1),
    localparam int ST_W  = tlf_pkg::TIME_W + LOG_N,
    localparam int SS_W  = tlf_pkg::SPEED_W + LOG_N,
    localparam int STS_W = tlf_pkg::TIME_W + tlf_pkg::SPEED_W + LOG_N,
    localparam int STT_W = 2 * tlf_pkg::TIME_W + LOG_N,
    localparam int SSS_W = 2 * tlf_pkg::SPEED_W + LOG_N
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_accept,
    input  logic [tlf_pkg::TIME_W-1:0]  in_time,
    input  logic [tlf_pkg::SPEED_W-1:0] in_speed,
    input  logic                        in_last,
    input  logic                        clr,
    output logic                        ready,
    output logic                        go,
    output logic [CNT_W-1:0]            count,
    output logic [ST_W-1:0]             sum_t,
    output logic [SS_W-1:0]             sum_s,
    output logic [STS_W-1:0]            sum_ts,
    output logic [STT_W-1:0]            sum_tt,
    output logic [SSS_W-1:0]            sum_ss,
    output logic [tlf_pkg::TIME_W-1:0]  first_time,
    output logic [tlf_pkg::TIME_W-1:0]  last_time
);
    import tlf_pkg::*;

    localparam int MC_T_W  = TIME_W + SPEED_W;
    localparam int MC_S_W  = 2 * SPEED_W;
    localparam int SER_C_W = $clog2(SPEED_W + 1);

    logic [CNT_W-1:0]   count_reg;
    logic [ST_W-1:0]    sum_t_reg;
    logic [SS_W-1:0]    sum_s_reg;
    logic [STS_W-1:0]   sum_ts_reg;
    logic [STT_W-1:0]   sum_tt_reg;
    logic [SSS_W-1:0]   sum_ss_reg;
    logic [TIME_W-1:0]  first_reg;
    logic [TIME_W-1:0]  last_reg;
    logic [MC_T_W-1:0]  t_mc_reg;
    logic [MC_S_W-1:0]  s_mc_reg;
    logic [TIME_W-1:0]  t_sh_reg;
    logic [SPEED_W-1:0] s_sh_reg;
    logic [SER_C_W-1:0] ser_cnt_reg;
    logic               busy_reg;
    logic               go_pend_reg;
    logic               room;

    assign room  = count_reg < CNT_W'(MAX_POINTS);
    assign ready = !busy_reg && !go_pend_reg;
    assign go    = go_pend_reg && !busy_reg;

    // Load samples, then shift-add the three products one bit a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            sum_t_reg   <= '0;
            sum_s_reg   <= '0;
            sum_ts_reg  <= '0;
            sum_tt_reg  <= '0;
            sum_ss_reg  <= '0;
            first_reg   <= '0;
            last_reg    <= '0;
            t_mc_reg    <= '0;
            s_mc_reg    <= '0;
            t_sh_reg    <= '0;
            s_sh_reg    <= '0;
            ser_cnt_reg <= '0;
            busy_reg    <= 1'b0;
            go_pend_reg <= 1'b0;
        end
        else if (clr)
        begin
            count_reg   <= '0;
            sum_t_reg   <= '0;
            sum_s_reg   <= '0;
            sum_ts_reg  <= '0;
            sum_tt_reg  <= '0;
            sum_ss_reg  <= '0;
            go_pend_reg <= 1'b0;
        end
        else
        begin
            if (go)
            begin
                go_pend_reg <= 1'b0;
            end
            // take one item, drop it when the store is full
            if (in_accept)
            begin
                go_pend_reg <= in_last;
                if (room)
                begin
                    if (count_reg == '0)
                    begin
                        first_reg <= in_time;
                    end
                    last_reg    <= in_time;
                    count_reg   <= count_reg + 1'b1;
                    sum_t_reg   <= sum_t_reg + ST_W'(in_time);
                    sum_s_reg   <= sum_s_reg + SS_W'(in_speed);
                    t_mc_reg    <= MC_T_W'(in_time);
                    s_mc_reg    <= MC_S_W'(in_speed);
                    t_sh_reg    <= in_time;
                    s_sh_reg    <= in_speed;
                    ser_cnt_reg <= SER_C_W'(SPEED_W);
                    busy_reg    <= 1'b1;
                end
            end
            // advance the serial products
            if (busy_reg)
            begin
                if (s_sh_reg[0])
                begin
                    sum_ts_reg <= sum_ts_reg + STS_W'(t_mc_reg);
                    sum_ss_reg <= sum_ss_reg + SSS_W'(s_mc_reg);
                end
                if (t_sh_reg[0])
                begin
                    sum_tt_reg <= sum_tt_reg + STT_W'(t_mc_reg);
                end
                t_mc_reg    <= t_mc_reg << 1;
                s_mc_reg    <= s_mc_reg << 1;
                t_sh_reg    <= t_sh_reg >> 1;
                s_sh_reg    <= s_sh_reg >> 1;
                ser_cnt_reg <= ser_cnt_reg - 1'b1;
                if (ser_cnt_reg == SER_C_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign count      = count_reg;
    assign sum_t      = sum_t_reg;
    assign sum_s      = sum_s_reg;
    assign sum_ts     = sum_ts_reg;
    assign sum_tt     = sum_tt_reg;
    assign sum_ss     = sum_ss_reg;
    assign first_time = first_reg;
    assign last_time  = last_reg;

endmodule

### hdl/tlf_mul.sv
module tlf_mul #(
    parameter int A_W = 132,
    parameter int B_W = 60
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [A_W-1:0] a,
    input  logic [B_W-1:0] b,
    output logic           busy,
    output logic           done,
    output logic [A_W-1:0] p
);
    localparam int C_W = $clog2(B_W + 1);

    logic [A_W-1:0] a_sh_reg;
    logic [B_W-1:0] b_sh_reg;
    logic [A_W-1:0] acc_reg;
    logic [C_W-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    // Shift-add: one multiplier bit per cycle, product truncated to A_W
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_sh_reg <= '0;
            b_sh_reg <= '0;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            // flag the last shift-add step
            done_reg <= busy_reg && !start && (cnt_reg == C_W'(1));
            if (start)
            begin
                a_sh_reg <= a;
                b_sh_reg <= b;
                acc_reg  <= '0;
                cnt_reg  <= C_W'(B_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (b_sh_reg[0])
                begin
                    acc_reg <= acc_reg + a_sh_reg;
                end
                a_sh_reg <= a_sh_reg << 1;
                b_sh_reg <= b_sh_reg >> 1;
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == C_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign p    = acc_reg;

endmodule

### hdl/tlf_div.sv
module tlf_div #(
    parameter int D_W = 132
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [D_W-1:0] num,
    input  logic [D_W-1:0] den,
    output logic           busy,
    output logic           done,
    output logic [D_W-1:0] q,
    output logic [D_W-1:0] r
);
    localparam int C_W = $clog2(D_W + 1);

    logic [D_W-1:0] num_sh_reg;
    logic [D_W-1:0] den_reg;
    logic [D_W-1:0] rem_reg;
    logic [D_W-1:0] q_reg;
    logic [C_W-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [D_W:0]   trial;
    logic           ge;

    // Restoring division, one quotient bit per cycle
    assign trial = {rem_reg, num_sh_reg[D_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_sh_reg <= '0;
            den_reg    <= '0;
            rem_reg    <= '0;
            q_reg      <= '0;
            cnt_reg    <= '0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            // flag the last quotient bit
            done_reg <= busy_reg && !start && (cnt_reg == C_W'(1));
            if (start)
            begin
                num_sh_reg <= num;
                den_reg    <= den;
                rem_reg    <= '0;
                q_reg      <= '0;
                cnt_reg    <= C_W'(D_W);
                busy_reg   <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg    <= ge ? D_W'(trial - {1'b0, den_reg}) : trial[D_W-1:0];
                q_reg      <= {q_reg[D_W-2:0], ge};
                num_sh_reg <= num_sh_reg << 1;
                cnt_reg    <= cnt_reg - 1'b1;
                if (cnt_reg == C_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign q    = q_reg;
    assign r    = rem_reg;

endmodule

### hdl/tlf_fit.sv
`include "trajectory_line_fit_with_confidence_macros.svh"
module tlf_fit #(
    parameter int MAX_POINTS = tlf_pkg::MAX_POINTS_DEF,
    localparam int LOG_N = $clog2(MAX_POINTS),
    localparam int CNT_W = $clog2(MAX_POINTS + 1),
    localparam int ST_W  = tlf_pkg::TIME_W + LOG_N,
    localparam int SS_W  = tlf_pkg::SPEED_W + LOG_N,
    localparam int STS_W = tlf_pkg::TIME_W + tlf_pkg::SPEED_W + LOG_N,
    localparam int STT_W = 2 * tlf_pkg::TIME_W + LOG_N,
    localparam int SSS_W = 2 * tlf_pkg::SPEED_W + LOG_N
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       go,
    input  logic [tlf_pkg::MINP_W-1:0] min_points,
    input  logic [CNT_W-1:0]           count,
    input  logic [ST_W-1:0]            sum_t,
    input  logic [SS_W-1:0]            sum_s,
    input  logic [STS_W-1:0]           sum_ts,
    input  logic [STT_W-1:0]           sum_tt,
    input  logic [SSS_W-1:0]           sum_ss,
    input  logic [tlf_pkg::TIME_W-1:0] first_time,
    input  logic [tlf_pkg::TIME_W-1:0] last_time,
    input  logic                       take,
    output tlf_pkg::fit_stat_t         stat,
    output tlf_pkg::fit_result_t       result
);
    import tlf_pkg::*;

    // Wide datapath: holds Dxy^2 * 2^16; narrow operand: holds any D term
    localparam int W      = 4 * LOG_N + 102;
    localparam int BW     = 2 * LOG_N + 44;
    localparam int CMP_W  = (CNT_W > MINP_W) ? CNT_W : MINP_W;
    localparam int ROOT_W = 2 * RMS_W;
    localparam int RC_W   = $clog2(RMS_W + 1);
    localparam int MN_W   = RMS_W + 8;
    localparam int MG_W   = RMS_W + 2;
    localparam int FRAC   = 16;
    localparam int MARGIN_MUL = 196;
    localparam int MARGIN_ADD = 50;
    localparam int MARGIN_DEN = 100;

    typedef enum logic [4:0] {
        ST_IDLE, ST_NXX, ST_SXX, ST_NXY, ST_SXY, ST_NYY, ST_SYY,
        ST_SLOPE, ST_SYXX, ST_SXXY, ST_ICPT, ST_DXY2, ST_PROD, ST_R2,
        ST_NN, ST_DEN, ST_VAR, ST_ROOT, ST_MARGIN, ST_DONE
    } step_t;

    step_t              step_reg;
    step_t              prev_step_reg;
    logic [W-1:0]       t1_reg;
    logic [W-1:0]       t2_reg;
    logic [W-1:0]       dxx_reg;
    logic [W-1:0]       dxy_reg;
    logic [W-1:0]       dyy_reg;
    logic               nxx_reg;
    logic               nxy_reg;
    logic               nyy_reg;
    logic               flat_reg;
    logic [ROOT_W-1:0]  v_reg;
    logic [ROOT_W-1:0]  res_reg;
    logic [ROOT_W-1:0]  bit_reg;
    logic [RC_W-1:0]    rcnt_reg;
    fit_result_t        out_reg;

    logic               issue;
    fit_result_t        start_res;
    logic               is_mul;
    logic               is_div;
    logic [W-1:0]       mul_a;
    logic [BW-1:0]      mul_b;
    logic [W-1:0]       div_num;
    logic [W-1:0]       div_den;
    logic               mul_busy;
    logic               mul_done;
    logic [W-1:0]       mul_p;
    logic               div_busy;
    logic               div_done;
    logic [W-1:0]       div_q;
    logic [W-1:0]       div_r;
    logic               d_ge;
    logic [W-1:0]       d_mag;
    logic               round_up;
    logic [W-1:0]       q_rnd;
    logic               q_big;
    logic [FIT_W-1:0]   pos_sat;
    logic [FIT_W-1:0]   neg_sat;
    logic [R2_W-1:0]    r2_val;
    logic [CMP_W-1:0]   need;
    logic               enough;
    logic [ROOT_W:0]    root_trial;
    logic               root_ge;
    logic [ROOT_W-1:0]  root_next;
    logic [MN_W-1:0]    margin_num;
    logic [MG_W-1:0]    margin;
    logic signed [FIT_W+1:0] icpt_ext;
    logic signed [FIT_W+1:0] lo_ext;
    logic signed [FIT_W+1:0] hi_ext;

    function automatic logic [FIT_W-1:0] clamp_fit(input logic signed [FIT_W+1:0] v);
        logic [FIT_W-1:0] rv;
        if (v[FIT_W+1:FIT_W-1] == 3'b000 || v[FIT_W+1:FIT_W-1] == 3'b111)
        begin
            rv = v[FIT_W-1:0];
        end
        else
        begin
            rv = v[FIT_W+1] ? {1'b1, {(FIT_W-1){1'b0}}} : {1'b0, {(FIT_W-1){1'b1}}};
        end
        return rv;
    endfunction

    // Start the shared unit on entry to any step that uses one
    assign issue = (step_reg != prev_step_reg) && (step_reg != ST_IDLE)
                   && (step_reg != ST_ROOT) && (step_reg != ST_DONE);

    // Pick operands for the shared multiplier and divider
    always_comb
    begin
        is_mul  = 1'b0;
        is_div  = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        div_num = '0;
        div_den = '0;
        unique case (step_reg)
            ST_NXX:    begin is_mul = 1'b1; mul_a = W'(sum_tt); mul_b = BW'(count); end
            ST_SXX:    begin is_mul = 1'b1; mul_a = W'(sum_t);  mul_b = BW'(sum_t);  end
            ST_NXY:    begin is_mul = 1'b1; mul_a = W'(sum_ts); mul_b = BW'(count); end
            ST_SXY:    begin is_mul = 1'b1; mul_a = W'(sum_s);  mul_b = BW'(sum_t);  end
            ST_NYY:    begin is_mul = 1'b1; mul_a = W'(sum_ss); mul_b = BW'(count); end
            ST_SYY:    begin is_mul = 1'b1; mul_a = W'(sum_s);  mul_b = BW'(sum_s);  end
            ST_SYXX:   begin is_mul = 1'b1; mul_a = W'(sum_tt); mul_b = BW'(sum_s);  end
            ST_SXXY:   begin is_mul = 1'b1; mul_a = W'(sum_ts); mul_b = BW'(sum_t);  end
            ST_DXY2:   begin is_mul = 1'b1; mul_a = dxy_reg; mul_b = dxy_reg[BW-1:0]; end
            ST_PROD:   begin is_mul = 1'b1; mul_a = dxx_reg; mul_b = dyy_reg[BW-1:0]; end
            ST_NN:     begin is_mul = 1'b1; mul_a = W'(count); mul_b = BW'(count); end
            ST_DEN:    begin is_mul = 1'b1; mul_a = dxx_reg; mul_b = t1_reg[BW-1:0]; end
            ST_SLOPE:  begin is_div = 1'b1; div_num = dxy_reg << FRAC; div_den = dxx_reg; end
            ST_ICPT:   begin is_div = 1'b1; div_num = t1_reg; div_den = dxx_reg; end
            ST_R2:     begin is_div = 1'b1; div_num = t2_reg << FRAC; div_den = t1_reg; end
            ST_VAR:
            begin
                is_div  = 1'b1;
                div_num = flat_reg ? W'(sum_ss) : t2_reg;
                div_den = flat_reg ? W'(count) : t1_reg;
            end
            ST_MARGIN: begin is_div = 1'b1; div_num = W'(margin_num); div_den = W'(MARGIN_DEN); end
            default:   ;
        endcase
    end

    // Fresh result at the start of a fit: validity and time span only
    always_comb
    begin
        start_res    = '0;
        start_res.ok = enough;
        if (count != '0 && last_time >= first_time)
        begin
            start_res.span = last_time - first_time;
        end
    end

    // Difference of the last two products, as magnitude and sign
    assign d_ge  = t1_reg >= mul_p;
    assign d_mag = d_ge ? t1_reg - mul_p : mul_p - t1_reg;

    // Round half up, then saturate to the signed output range
    assign round_up = {div_r, 1'b0} >= {1'b0, div_den};
    assign q_rnd    = div_q + W'(round_up);
    assign q_big    = |q_rnd[W-1:FIT_W-1];
    assign pos_sat  = (q_big || (&q_rnd[FIT_W-2:0])) ? {1'b0, {(FIT_W-1){1'b1}}}
                                                      : {1'b0, q_rnd[FIT_W-2:0]};
    assign neg_sat  = q_big ? {1'b1, {(FIT_W-1){1'b0}}}
                            : FIT_W'(-{1'b0, q_rnd[FIT_W-2:0]});
    assign r2_val   = (|q_rnd[W-1:FRAC]) ? R2_ONE : R2_W'(q_rnd[FRAC-1:0]);

    // Minimum count, never below two
    assign need   = (min_points < MINP_W'(2)) ? CMP_W'(2) : CMP_W'(min_points);
    assign enough = CMP_W'(count) >= need;

    // One step of the digit-by-digit square root
    assign root_trial = {1'b0, res_reg} + {1'b0, bit_reg};
    assign root_ge    = {1'b0, v_reg} >= root_trial;
    assign root_next  = root_ge ? (res_reg >> 1) + bit_reg : res_reg >> 1;

    // Interval half-width is 1.96 times the RMS
    assign margin_num = MN_W'(out_reg.rms) * MN_W'(MARGIN_MUL) + MN_W'(MARGIN_ADD);
    assign margin     = div_q[MG_W-1:0];
    assign icpt_ext   = {{2{out_reg.icpt[FIT_W-1]}}, out_reg.icpt};
    assign lo_ext     = icpt_ext - $signed({2'b00, FIT_W'(margin)});
    assign hi_ext     = icpt_ext + $signed({2'b00, FIT_W'(margin)});

    tlf_mul #(
        .A_W (W),
        .B_W (BW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (issue && is_mul),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .done  (mul_done),
        .p     (mul_p)
    );

    tlf_div #(
        .D_W (W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (issue && is_div),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .q     (div_q),
        .r     (div_r)
    );

    // Sequence the fit: products, differences, quotients, root
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_IDLE;
            prev_step_reg <= ST_IDLE;
            t1_reg        <= '0;
            t2_reg        <= '0;
            dxx_reg       <= '0;
            dxy_reg       <= '0;
            dyy_reg       <= '0;
            nxx_reg       <= 1'b0;
            nxy_reg       <= 1'b0;
            nyy_reg       <= 1'b0;
            flat_reg      <= 1'b0;
            v_reg         <= '0;
            res_reg       <= '0;
            bit_reg       <= '0;
            rcnt_reg      <= '0;
            out_reg       <= '0;
        end
        else
        begin
            prev_step_reg <= step_reg;
            unique case (step_reg)
                ST_IDLE:
                begin
                    if (go)
                    begin
                        out_reg  <= start_res;
                        flat_reg <= 1'b0;
                        if (enough)
                        begin
                            step_reg <= ST_NXX;
                        end
                        else
                        begin
                            step_reg <= ST_DONE;
                        end
                    end
                end
                ST_NXX, ST_NXY, ST_NYY, ST_SYXX, ST_PROD, ST_NN, ST_DEN:
                begin
                    if (mul_done)
                    begin
                        t1_reg <= mul_p;
                        unique case (step_reg)
                            ST_NXX:  step_reg <= ST_SXX;
                            ST_NXY:  step_reg <= ST_SXY;
                            ST_NYY:  step_reg <= ST_SYY;
                            ST_SYXX: step_reg <= ST_SXXY;
                            ST_PROD: step_reg <= ST_R2;
                            ST_NN:   step_reg <= ST_DEN;
                            default: step_reg <= ST_VAR;
                        endcase
                    end
                end
                ST_SXX:
                begin
                    if (mul_done)
                    begin
                        dxx_reg  <= d_mag;
                        nxx_reg  <= !d_ge;
                        step_reg <= ST_NXY;
                    end
                end
                ST_SXY:
                begin
                    if (mul_done)
                    begin
                        dxy_reg  <= d_mag;
                        nxy_reg  <= !d_ge;
                        step_reg <= ST_NYY;
                    end
                end
                ST_SYY:
                begin
                    if (mul_done)
                    begin
                        dyy_reg <= d_mag;
                        nyy_reg <= !d_ge;
                        // flat time axis: fit about the zero line
                        if (nxx_reg || dxx_reg == '0)
                        begin
                            flat_reg <= 1'b1;
                            step_reg <= ST_VAR;
                        end
                        else
                        begin
                            step_reg <= ST_SLOPE;
                        end
                    end
                end
                ST_SLOPE:
                begin
                    if (div_done)
                    begin
                        out_reg.slope <= nxy_reg ? neg_sat : pos_sat;
                        step_reg      <= ST_SYXX;
                    end
                end
                ST_SXXY:
                begin
                    if (mul_done)
                    begin
                        t1_reg   <= d_mag;
                        nyy_reg  <= nyy_reg;
                        nxx_reg  <= !d_ge;
                        step_reg <= ST_ICPT;
                    end
                end
                ST_ICPT:
                begin
                    if (div_done)
                    begin
                        out_reg.icpt <= nxx_reg ? neg_sat : pos_sat;
                        step_reg     <= ST_DXY2;
                    end
                end
                ST_DXY2:
                begin
                    if (mul_done)
                    begin
                        // constant speed: no R-squared, no residual
                        if (!nyy_reg && dyy_reg != '0)
                        begin
                            t2_reg   <= mul_p;
                            step_reg <= ST_PROD;
                        end
                        else
                        begin
                            t2_reg   <= '0;
                            step_reg <= ST_NN;
                        end
                    end
                end
                ST_R2:
                begin
                    if (div_done)
                    begin
                        out_reg.r2 <= r2_val;
                        t2_reg     <= (t1_reg >= t2_reg) ? t1_reg - t2_reg : '0;
                        step_reg   <= ST_NN;
                    end
                end
                ST_VAR:
                begin
                    if (div_done)
                    begin
                        if (|div_q[W-1:ROOT_W])
                        begin
                            out_reg.rms <= '1;
                            step_reg    <= ST_MARGIN;
                        end
                        else
                        begin
                            v_reg    <= div_q[ROOT_W-1:0];
                            res_reg  <= '0;
                            bit_reg  <= ROOT_W'(1) << (ROOT_W - 2);
                            rcnt_reg <= RC_W'(RMS_W);
                            step_reg <= ST_ROOT;
                        end
                    end
                end
                ST_ROOT:
                begin
                    if (root_ge)
                    begin
                        v_reg <= v_reg - root_trial[ROOT_W-1:0];
                    end
                    res_reg  <= root_next;
                    bit_reg  <= bit_reg >> 2;
                    rcnt_reg <= rcnt_reg - 1'b1;
                    if (rcnt_reg == RC_W'(1))
                    begin
                        out_reg.rms <= root_next[RMS_W-1:0];
                        step_reg    <= ST_MARGIN;
                    end
                end
                ST_MARGIN:
                begin
                    if (div_done)
                    begin
                        out_reg.lo <= clamp_fit(lo_ext);
                        out_reg.hi <= clamp_fit(hi_ext);
                        step_reg   <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (take)
                    begin
                        step_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    step_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign stat.busy = step_reg != ST_IDLE;
    assign stat.done = step_reg == ST_DONE;
    assign result    = out_reg;

    `TLF_NEVER(a_one_unit, clk, rst_n, mul_busy && div_busy)
    `TLF_ASSERT(a_no_div_zero, clk, rst_n, (issue && is_div) |-> (div_den != '0))
    `TLF_ASSERT(a_root_done, clk, rst_n, (step_reg == ST_ROOT && rcnt_reg == RC_W'(1)) |=> (step_reg == ST_MARGIN))

endmodule

### hdl/trajectory_line_fit_with_confidence.sv
// Channel  | dir | item                       | accepted when
// s_axis   | in  | one (time, speed) sample   | s_axis_tvalid && s_axis_tready
// m_axis   | out | one fit result             | m_axis_tvalid && m_axis_tready
// cfg      | in  | min_points write           | cfg_wr_en
// A stored sample is folded in by a shift-add of its three products, one bit a cycle,
// and the next sample waits until it is through. The fit after the last sample runs
// on a bit-serial multiplier and divider, one unit at a time.
// Samples are refused while the fit runs; a finished result waits in the output register.
// Reset clears counts and sums; min_points returns to 5.
`include "trajectory_line_fit_with_confidence_macros.svh"
module trajectory_line_fit_with_confidence #(
    parameter int MAX_POINTS = tlf_pkg::MAX_POINTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [tlf_pkg::MINP_W-1:0]      cfg_wr_data,    // min_points
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [tlf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // sample_time, sample_speed
    input  logic                            s_axis_tlast,   // last_sample
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // fit_slope, fit_intercept, fit_r_squared, residual_rms, interval_low,
    // interval_high, span_time
    output logic [tlf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tuser    // fit_ok
);
    import tlf_pkg::*;

    localparam int LOG_N = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int ST_W  = TIME_W + LOG_N;
    localparam int SS_W  = SPEED_W + LOG_N;
    localparam int STS_W = TIME_W + SPEED_W + LOG_N;
    localparam int STT_W = 2 * TIME_W + LOG_N;
    localparam int SSS_W = 2 * SPEED_W + LOG_N;
    localparam int RES_W = 4 * FIT_W + R2_W + RMS_W + SPAN_W;

    logic [MINP_W-1:0]  min_points_reg;
    logic               m_valid_reg;
    fit_result_t        res_reg;
    logic               acc_ready;
    logic               go;
    logic               in_accept;
    logic               res_take;
    logic [CNT_W-1:0]   count;
    logic [ST_W-1:0]    sum_t;
    logic [SS_W-1:0]    sum_s;
    logic [STS_W-1:0]   sum_ts;
    logic [STT_W-1:0]   sum_tt;
    logic [SSS_W-1:0]   sum_ss;
    logic [TIME_W-1:0]  first_time;
    logic [TIME_W-1:0]  last_time;
    fit_stat_t          fit_stat;
    fit_result_t        fit_res;

    assign s_axis_tready = acc_ready && !fit_stat.busy;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign res_take      = fit_stat.done && (!m_valid_reg || m_axis_tready);

    tlf_acc #(
        .MAX_POINTS (MAX_POINTS)
    ) u_acc (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_accept  (in_accept),
        .in_time    (s_axis_tdata[TIME_W-1:0]),
        .in_speed   (s_axis_tdata[TIME_W+SPEED_W-1:TIME_W]),
        .in_last    (s_axis_tlast),
        .clr        (res_take),
        .ready      (acc_ready),
        .go         (go),
        .count      (count),
        .sum_t      (sum_t),
        .sum_s      (sum_s),
        .sum_ts     (sum_ts),
        .sum_tt     (sum_tt),
        .sum_ss     (sum_ss),
        .first_time (first_time),
        .last_time  (last_time)
    );

    tlf_fit #(
        .MAX_POINTS (MAX_POINTS)
    ) u_fit (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .min_points (min_points_reg),
        .count      (count),
        .sum_t      (sum_t),
        .sum_s      (sum_s),
        .sum_ts     (sum_ts),
        .sum_tt     (sum_tt),
        .sum_ss     (sum_ss),
        .first_time (first_time),
        .last_time  (last_time),
        .take       (res_take),
        .stat       (fit_stat),
        .result     (fit_res)
    );

    // Hold the configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_points_reg <= MINP_RESET;
        end
        else if (cfg_wr_en)
        begin
            min_points_reg <= cfg_wr_data;
        end
    end

    // Output register: load a finished fit, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            res_reg     <= '0;
        end
        else
        begin
            if (res_take)
            begin
                m_valid_reg <= 1'b1;
                res_reg     <= fit_res;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = res_reg.ok;
    assign m_axis_tdata  = {(OUT_TDATA_W - RES_W)'(0), res_reg.span, res_reg.hi, res_reg.lo,
                            res_reg.rms, res_reg.r2, res_reg.icpt, res_reg.slope};

    `TLF_NEVER(a_no_load_in_fit, clk, rst_n, in_accept && fit_stat.busy)
    `TLF_ASSERT(a_r2_range, clk, rst_n, m_valid_reg |-> (res_reg.r2 <= R2_ONE))
    `TLF_ASSERT(a_bad_fit_zero, clk, rst_n, (m_valid_reg && !res_reg.ok) |-> (res_reg.slope == '0 && res_reg.rms == '0))
    `TLF_ASSERT(a_take_loads, clk, rst_n, res_take |=> m_valid_reg)

endmodule

### tb/sv/trajectory_line_fit_with_confidence_tb.sv
`timescale 1ns / 100ps

module trajectory_line_fit_with_confidence_tb;
    import tlf_pkg::*;

    typedef bit [255:0] wide_t;

    localparam int  STORE_DEPTH = MAX_POINTS_DEF;
    localparam int  TIME_MAX    = (1 << TIME_W) - 1;
    localparam int  SPEED_MAX   = (1 << SPEED_W) - 1;
    localparam int  RAND_ITEMS  = 330;
    localparam int  DRAIN_WAIT  = 1600;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [MINP_W-1:0]      cfg_wr_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // sample_time, sample_speed
    logic                   s_axis_tlast;   // last_sample
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // fit_slope, fit_intercept, fit_r_squared, residual_rms, interval_low,
    // interval_high, span_time
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;   // fit_ok

    trajectory_line_fit_with_confidence DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Predictor state: one trajectory being accumulated
    int unsigned      acc_count;
    bit [63:0]        acc_sx, acc_sy, acc_sxy, acc_sxx, acc_syy;
    bit [TIME_W-1:0]  acc_first_time, acc_last_time;
    bit [MINP_W-1:0]  min_points_cfg;

    fit_result_t      fit_expect_q[$];
    int               tx_gap_max;
    int               rx_stall_max;
    int               rx_stall_cnt;
    int               mismatch_cnt;
    int               fits_checked;
    int               fits_ok_seen;
    int               samples_sent;

    // Clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic wide_t mag_diff(input wide_t a, input wide_t b, output bit neg);
        neg = (a < b);
        return neg ? b - a : a - b;
    endfunction

    // Round half up of num * 2^shift / den
    function automatic wide_t div_round_up(input wide_t num, input wide_t den, input int shift);
        wide_t q;
        wide_t r;
        num = num << shift;
        q = num / den;
        r = num % den;
        if ((r << 1) >= den)
            q = q + 1;
        return q;
    endfunction

    function automatic logic signed [FIT_W-1:0] sat_int32(input wide_t mag, input bit neg);
        if (neg)
            return (mag >= 256'h8000_0000) ? 32'sh8000_0000 : -$signed(mag[31:0]);
        return (mag >= 256'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(mag[31:0]);
    endfunction

    // floor(sqrt(num/den)), saturated to the rms width
    function automatic logic [RMS_W-1:0] rms_root(input wide_t num, input wide_t den);
        wide_t q;
        bit [63:0] root;
        q = num / den;
        if (q >= (256'd1 << 44))
            return {RMS_W{1'b1}};
        root = 0;
        for (int b = 21; b >= 0; b--)
            if ((root | (64'd1 << b)) * (root | (64'd1 << b)) <= q[63:0])
                root = root | (64'd1 << b);
        return root[RMS_W-1:0];
    endfunction

    function automatic logic signed [FIT_W-1:0] clamp_int32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Least-squares fit over the accumulated trajectory
    function automatic fit_result_t line_fit_predict();
        fit_result_t res;
        wide_t n, sx, sy, sxx, syy, sxy, dxx, dxy, dyy, mag, dxy2, prod, resid;
        bit nxx, nxy, nyy, nic, rneg;
        int unsigned need;
        longint margin;
        res = '0;
        need = (min_points_cfg < 2) ? 2 : min_points_cfg;
        if (acc_count > 0 && acc_last_time >= acc_first_time)
            res.span = acc_last_time - acc_first_time;
        if (acc_count >= need)
        begin
            n = acc_count;
            sx = acc_sx;
            sy = acc_sy;
            sxx = acc_sxx;
            syy = acc_syy;
            sxy = acc_sxy;
            dxx = mag_diff(n * sxx, sx * sx, nxx);
            dxy = mag_diff(n * sxy, sx * sy, nxy);
            dyy = mag_diff(n * syy, sy * sy, nyy);
            res.ok = 1'b1;
            if (nxx || dxx == 0)
                res.rms = rms_root(syy, n);
            else
            begin
                res.slope = sat_int32(div_round_up(dxy, dxx, 16), nxy);
                mag = mag_diff(sy * sxx, sx * sxy, nic);
                res.icpt = sat_int32(div_round_up(mag, dxx, 0), nic);
                dxy2 = dxy * dxy;
                resid = 0;
                if (!nyy && dyy != 0)
                begin
                    prod = dxx * dyy;
                    mag = div_round_up(dxy2, prod, 16);
                    res.r2 = (mag >= 65536) ? R2_ONE : mag[R2_W-1:0];
                    resid = mag_diff(prod, dxy2, rneg);
                    if (rneg)
                        resid = 0;
                end
                res.rms = rms_root(resid, n * n * dxx);
            end
            margin = (longint'(res.rms) * 196 + 50) / 100;
            res.lo = clamp_int32(longint'(res.icpt) - margin);
            res.hi = clamp_int32(longint'(res.icpt) + margin);
        end
        return res;
    endfunction

    // Fold one accepted item into the predictor
    task automatic accumulate_sample(input bit [TIME_W-1:0] t, input bit [SPEED_W-1:0] s,
                                     input bit last);
        if (acc_count < STORE_DEPTH)
        begin
            if (acc_count == 0)
                acc_first_time = t;
            acc_last_time = t;
            acc_count++;
            acc_sx += t;
            acc_sy += s;
            acc_sxy += 64'(t) * 64'(s);
            acc_sxx += 64'(t) * 64'(t);
            acc_syy += 64'(s) * 64'(s);
        end
        if (last)
        begin
            fit_expect_q = {fit_expect_q, line_fit_predict()};
            acc_count = 0;
            acc_sx = 0;
            acc_sy = 0;
            acc_sxy = 0;
            acc_sxx = 0;
            acc_syy = 0;
        end
    endtask

    // Send one item, with a random gap ahead of it
    task automatic send_sample(input int t, input int s, input bit last);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, s[SPEED_W-1:0], t[TIME_W-1:0]};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        samples_sent++;
        accumulate_sample(t[TIME_W-1:0], s[SPEED_W-1:0], last);
    endtask

    // Hold off until every expected fit has arrived
    task automatic wait_fits_done();
        s_axis_tvalid <= 1'b0;
        while (fit_expect_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_min_points(input int value);
        wait_fits_done();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[MINP_W-1:0];
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        min_points_cfg = value[MINP_W-1:0];
    endtask

    // Rolling ball: speed falls linearly with time, plus some noise
    task automatic send_rolling(input int len);
        int t, dt, v0, decel, noise, s;
        t = $urandom_range(0, 4000);
        dt = $urandom_range(100, 9000);
        v0 = $urandom_range(0, SPEED_MAX);
        decel = $urandom_range(0, 40);
        noise = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 20000);
        for (int i = 0; i < len; i++)
        begin
            s = v0 - (decel * (t >> 4)) + $urandom_range(0, 2 * noise) - noise;
            s = (s < 0) ? 0 : (s > SPEED_MAX ? SPEED_MAX : s);
            send_sample(t > TIME_MAX ? TIME_MAX : t, s, i == len - 1);
            t += dt;
        end
    endtask

    task automatic send_noise(input int len);
        for (int i = 0; i < len; i++)
            send_sample($urandom_range(0, TIME_MAX), $urandom_range(0, SPEED_MAX), i == len - 1);
    endtask

    // Extremes and degenerate trajectories
    task automatic test_special_cases();
        // ideal ramp
        for (int i = 0; i < 6; i++)
            send_sample(i * 1000, 100000 - i * 500, i == 5);
        // field extremes, steep slope, saturation
        send_sample(0, SPEED_MAX, 1'b0);
        send_sample(1, 0, 1'b0);
        send_sample(TIME_MAX, SPEED_MAX, 1'b0);
        send_sample(0, 0, 1'b0);
        send_sample(2, SPEED_MAX, 1'b1);
        // all at one time: zero time variance
        for (int i = 0; i < 5; i++)
            send_sample(7777, 3000 * i, i == 4);
        // constant speed: zero speed variance
        for (int i = 0; i < 5; i++)
            send_sample(500 * i, 42, i == 4);
        // time running backward: span clamps to zero
        for (int i = 0; i < 5; i++)
            send_sample(9000 - 1000 * i, 5000 + 17 * i * i, i == 4);
        // too few samples
        send_sample(123, 456, 1'b1);
        send_sample(TIME_MAX, SPEED_MAX, 1'b1);
    endtask

    // min_points settings, including the ones that act as two
    task automatic test_min_points();
        int vals[4] = '{0, 1, 2, 511};
        foreach (vals[k])
        begin
            write_min_points(vals[k]);
            send_rolling(2);
            send_rolling(3);
        end
        write_min_points(MINP_RESET);
    endtask

    // Overfill the store; dropped items still end the trajectory
    task automatic test_store_full();
        write_min_points(256);
        tx_gap_max = 0;
        send_rolling(STORE_DEPTH + 4);
        send_rolling(STORE_DEPTH - 1);
        tx_gap_max = 16;
        write_min_points(MINP_RESET);
    endtask

    task automatic test_random_trajectories();
        int start, kind;
        start = samples_sent;
        while (samples_sent - start < RAND_ITEMS)
        begin
            kind = $urandom_range(0, 19);
            tx_gap_max = ($urandom_range(0, 4) == 0) ? 0 : 16;
            rx_stall_max = ($urandom_range(0, 4) == 0) ? 0 : 16;
            if (kind == 0)
                write_min_points($urandom_range(2, 10));
            else if (kind == 1)
                wait_fits_done();
            if (kind < 14)
                send_rolling($urandom_range(2, 12));
            else
                send_noise($urandom_range(1, 10));
        end
        tx_gap_max = 16;
        rx_stall_max = 16;
        write_min_points(2);
        write_min_points(MINP_RESET);
    endtask

    // Receiver: random stalls, check each fit against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        fit_result_t exp_fit;
        fit_result_t got;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_stall_cnt = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.ok    = m_axis_tuser;
                got.slope = m_axis_tdata[31:0];
                got.icpt  = m_axis_tdata[63:32];
                got.r2    = m_axis_tdata[80:64];
                got.rms   = m_axis_tdata[102:81];
                got.lo    = m_axis_tdata[134:103];
                got.hi    = m_axis_tdata[166:135];
                got.span  = m_axis_tdata[186:167];
                if (fit_expect_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected fit result: %p", got);
                end
                else
                begin
                    exp_fit = fit_expect_q.pop_front();
                    fits_checked++;
                    if (got.ok)
                        fits_ok_seen++;
                    if (got !== exp_fit)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("fit mismatch\n  expected %p\n  actual   %p", exp_fit, got);
                    end
                end
                rx_stall_cnt = $urandom_range(0, rx_stall_max);
            end
            else if (rx_stall_cnt > 0)
                rx_stall_cnt--;
            m_axis_tready <= (rx_stall_cnt == 0);
        end
    end

    // Run limit
    initial
    begin
        #200_000_000;
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        min_points_cfg = MINP_RESET;
        acc_count = 0;
        acc_sx = 0;
        acc_sy = 0;
        acc_sxy = 0;
        acc_sxx = 0;
        acc_syy = 0;
        tx_gap_max = 16;
        rx_stall_max = 16;
        mismatch_cnt = 0;
        fits_checked = 0;
        fits_ok_seen = 0;
        samples_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_cases();
        test_min_points();
        test_store_full();
        test_random_trajectories();

        wait_fits_done();
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("sent %0d samples; checked %0d fits (%0d valid), %0d mismatches",
                 samples_sent, fits_checked, fits_ok_seen, mismatch_cnt);
        $display("covered degenerate variances, short and overfull trajectories, min_points sweep");
        if (mismatch_cnt == 0 && fit_expect_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/tlf_pkg.sv
hdl/tlf_acc.sv
hdl/tlf_mul.sv
hdl/tlf_div.sv
hdl/tlf_fit.sv
hdl/trajectory_line_fit_with_confidence.sv
tb/sv/trajectory_line_fit_with_confidence_tb.sv
